### design/brb_pkg.sv
`timescale 1ns / 1ps

package brb_pkg;

   // Ring storage depth; the slot indices are sized from it.
   localparam int DEPTH = 1024;
   localparam int IDX_W = $clog2(DEPTH);
   localparam int CAP_W = 10;
   // Working width for index sums, fill counts and capacity values.
   localparam int SUM_W = ((IDX_W > CAP_W) ? IDX_W : CAP_W) + 1;

   localparam logic [CAP_W-1:0] CAP_RESET = 10'd1023;

   localparam logic [2:0] OP_PUSH_OVR = 3'd0;
   localparam logic [2:0] OP_PUSH     = 3'd1;
   localparam logic [2:0] OP_POP      = 3'd2;
   localparam logic [2:0] OP_PEEK     = 3'd3;
   localparam logic [2:0] OP_DISCARD  = 3'd4;
   localparam logic [2:0] OP_CLEAR    = 3'd5;

   typedef struct packed {
      logic [2:0] opcode;
      logic [7:0] data_byte;
      logic [9:0] count;
   } brb_req_type;

   typedef struct packed {
      logic [7:0] data_out;
      logic       ok;
      logic       dropped_oldest;
      logic [9:0] moved;
      logic [9:0] used_count;
      logic [9:0] free_count;
      logic [9:0] contiguous_span;
   } brb_rsp_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic accept;
      logic prep;
      logic exec;
      logic finish;
   } brb_cmd_type;

endpackage

### design/brb_ctrl.sv
`timescale 1ns / 1ps

module brb_ctrl import brb_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output brb_cmd_type cmd
);

   typedef enum logic [3:0] {
      S_IDLE = 4'b0001,
      S_PREP = 4'b0010,
      S_EXEC = 4'b0100,
      S_DONE = 4'b1000
   } brb_state_type;

   brb_state_type state_ff, state_in;
   logic          rsp_valid_ff, rsp_valid_in;

   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff;
      cmd          = '0;
      // A waiting result leaves once it has been taken.
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.accept = 1'b1;
               state_in   = S_PREP;
            end
         end
         S_PREP: begin
            cmd.prep = 1'b1;
            state_in = S_EXEC;
         end
         S_EXEC: begin
            cmd.exec = 1'b1;
            state_in = S_DONE;
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.finish   = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;

endmodule

### design/brb_datapath.sv
`timescale 1ns / 1ps

module brb_datapath import brb_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  brb_cmd_type      cmd,
   input  brb_req_type      req_data,
   input  logic             csr_we,
   input  logic [CAP_W-1:0] csr_wdata,
   output brb_rsp_type      rsp_data
);

   localparam logic [SUM_W-1:0] MAX_CAP = SUM_W'(DEPTH - 1);

   function automatic logic [SUM_W-1:0] clamp_cap(input logic [CAP_W-1:0] c);
      logic [SUM_W-1:0] v;
      v = {{(SUM_W-CAP_W){1'b0}}, c};
      if (v == '0) begin
         v = SUM_W'(1);
      end else if (v > MAX_CAP) begin
         v = MAX_CAP;
      end
      return v;
   endfunction

   function automatic logic [SUM_W-1:0] zext(input logic [IDX_W-1:0] idx);
      return {{(SUM_W-IDX_W){1'b0}}, idx};
   endfunction

   // Reduce a sum below twice the slot count back into the ring.
   function automatic logic [IDX_W-1:0] wrap(input logic [SUM_W-1:0] t,
                                            input logic [SUM_W-1:0] slots);
      logic [SUM_W-1:0] r;
      r = (t >= slots) ? (t - slots) : t;
      return r[IDX_W-1:0];
   endfunction

   logic [7:0]       mem [DEPTH];

   logic [SUM_W-1:0] eff_cap_ff;
   logic [IDX_W-1:0] rd_idx_ff, rd_idx_in;
   logic [IDX_W-1:0] wr_idx_ff, wr_idx_in;
   brb_req_type      req_ff;
   logic [SUM_W-1:0] used_ff;
   logic [SUM_W-1:0] sum_ff;
   logic             ok_ff, ok_in;
   logic             drop_ff, drop_in;
   logic             rd_op_ff, rd_op_in;
   logic [SUM_W-1:0] moved_ff, moved_in;
   logic [7:0]       rd_data_ff;
   brb_rsp_type      rsp_ff;

   logic [SUM_W-1:0] slots;
   logic [SUM_W-1:0] used_now;
   logic [SUM_W-1:0] to_end;
   logic [SUM_W-1:0] span;
   logic [SUM_W-1:0] free_now;
   logic [SUM_W-1:0] cnt_ext;
   logic             full;
   logic             mem_we;
   logic [IDX_W-1:0] rd_addr;

   assign slots   = eff_cap_ff + SUM_W'(1);
   assign cnt_ext = {{(SUM_W-CAP_W){1'b0}}, req_ff.count};
   assign full    = (used_ff >= eff_cap_ff);

   assign used_now = (wr_idx_ff >= rd_idx_ff) ? (zext(wr_idx_ff) - zext(rd_idx_ff))
                                              : (slots - zext(rd_idx_ff) + zext(wr_idx_ff));
   assign to_end   = slots - zext(rd_idx_ff);
   assign span     = (used_now < to_end) ? used_now : to_end;
   assign free_now = eff_cap_ff - used_now;

   always_comb begin
      rd_idx_in = rd_idx_ff;
      wr_idx_in = wr_idx_ff;
      ok_in     = 1'b0;
      drop_in   = 1'b0;
      rd_op_in  = 1'b0;
      moved_in  = '0;
      mem_we    = 1'b0;
      rd_addr   = rd_idx_ff;
      case (req_ff.opcode)
         OP_PUSH_OVR: begin
            if (full) begin
               rd_idx_in = wrap(zext(rd_idx_ff) + SUM_W'(1), slots);
               drop_in   = 1'b1;
            end
            mem_we    = 1'b1;
            wr_idx_in = wrap(zext(wr_idx_ff) + SUM_W'(1), slots);
            ok_in     = 1'b1;
         end
         OP_PUSH: begin
            if (!full) begin
               mem_we    = 1'b1;
               wr_idx_in = wrap(zext(wr_idx_ff) + SUM_W'(1), slots);
               ok_in     = 1'b1;
            end
         end
         OP_POP: begin
            if (used_ff != '0) begin
               rd_idx_in = wrap(zext(rd_idx_ff) + SUM_W'(1), slots);
               rd_op_in  = 1'b1;
               ok_in     = 1'b1;
            end
         end
         OP_PEEK: begin
            rd_addr = wrap(sum_ff, slots);
            if (cnt_ext < used_ff) begin
               rd_op_in = 1'b1;
               ok_in    = 1'b1;
            end
         end
         OP_DISCARD: begin
            moved_in  = (cnt_ext < used_ff) ? cnt_ext : used_ff;
            rd_idx_in = wrap(zext(rd_idx_ff) + moved_in, slots);
            ok_in     = 1'b1;
         end
         OP_CLEAR: begin
            rd_idx_in = '0;
            wr_idx_in = '0;
            ok_in     = 1'b1;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         eff_cap_ff <= clamp_cap(CAP_RESET);
         rd_idx_ff  <= '0;
         wr_idx_ff  <= '0;
      end else if (csr_we) begin
         eff_cap_ff <= clamp_cap(csr_wdata);
         rd_idx_ff  <= '0;
         wr_idx_ff  <= '0;
      end else if (cmd.exec) begin
         rd_idx_ff <= rd_idx_in;
         wr_idx_ff <= wr_idx_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         req_ff <= req_data;
      end
      if (cmd.prep) begin
         used_ff <= used_now;
         sum_ff  <= zext(rd_idx_ff) + cnt_ext;
      end
      if (cmd.exec) begin
         ok_ff    <= ok_in;
         drop_ff  <= drop_in;
         rd_op_ff <= rd_op_in;
         moved_ff <= moved_in;
      end
      if (cmd.finish) begin
         rsp_ff.data_out        <= rd_op_ff ? rd_data_ff : 8'd0;
         rsp_ff.ok              <= ok_ff;
         rsp_ff.dropped_oldest  <= drop_ff;
         rsp_ff.moved           <= moved_ff[CAP_W-1:0];
         rsp_ff.used_count      <= used_now[CAP_W-1:0];
         rsp_ff.free_count      <= free_now[CAP_W-1:0];
         rsp_ff.contiguous_span <= span[CAP_W-1:0];
      end
   end

   // Byte storage: at most one write and one registered read per item.
   always_ff @(posedge clock) begin
      if (cmd.exec) begin
         if (mem_we) begin
            mem[wr_idx_ff] <= req_ff.data_byte;
         end
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rsp_data = rsp_ff;

endmodule

### design/byte_ring_buffer_fifo.sv
`timescale 1ns / 1ps
// Channel   Direction  Handshake              Payload
// req       in         req_valid / req_ready  brb_req_type (opcode, data_byte, count)
// rsp       out        rsp_valid / rsp_ready  brb_rsp_type (data, flags, fill state)
// csr       in         csr_we                 capacity, 10 bits
//
// Each item goes through these steps in order: accept, fill count
// and peek sum, one storage access with the index update, then the result load.
// A result that waits in the output register delays only the final step of the next item.
// Reset is synchronous and empties the ring with capacity 1023; a capacity write empties it too.
// No clearing pass is needed, since only bytes that were written can be read back.

module byte_ring_buffer_fifo import brb_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  brb_req_type      req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output brb_rsp_type      rsp_data,
   input  logic             csr_we,
   input  logic [CAP_W-1:0] csr_wdata
);

   brb_cmd_type cmd;

   brb_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .cmd       (cmd)
   );

   brb_datapath u_datapath (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .req_data  (req_data),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata),
      .rsp_data  (rsp_data)
   );

   // Once a transfer is taken, the controller is busy with it in the next cycle.
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("input taken again straight after a transfer");

   // Dropping the oldest byte leaves the ring full.
   a_drop_means_full: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.dropped_oldest) |-> (rsp_data.ok && rsp_data.free_count == 10'd0))
      else $error("overwrite drop without a full ring");

   // A failed operation returns no data and moves nothing.
   a_fail_is_quiet: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_data.ok) |-> (rsp_data.data_out == 8'd0 && rsp_data.moved == 10'd0))
      else $error("failed operation reports data or movement");

   // The readable span never exceeds the bytes held.
   a_span_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.contiguous_span <= rsp_data.used_count))
      else $error("contiguous span exceeds bytes held");

endmodule

### tb/byte_ring_buffer_fifo_test.sv
`timescale 1ns / 1ps

import brb_pkg::*;

// Tracks the ring exactly as the block should hold it and keeps the results that the
// accepted requests are due to produce, oldest first.
class byte_ring_tracker;
   brb_rsp_type pending_results[$];
   logic [7:0]  ring_bytes [DEPTH];
   int          oldest_slot;
   int          next_slot;
   int          capacity_reg;
   int          errors;

   function new();
      foreach (ring_bytes[i]) ring_bytes[i] = '0;
      oldest_slot  = 0;
      next_slot    = 0;
      capacity_reg = int'(CAP_RESET);
      errors       = 0;
   endfunction

   // A capacity write also empties the ring.
   function void load_capacity(logic [CAP_W-1:0] value);
      capacity_reg = int'(value);
      oldest_slot  = 0;
      next_slot    = 0;
   endfunction

   function int usable();
      int cap;
      cap = capacity_reg;
      if (cap < 1) cap = 1;
      if (cap > DEPTH - 1) cap = DEPTH - 1;
      return cap;
   endfunction

   function int bytes_held();
      int slots;
      slots = usable() + 1;
      if (next_slot >= oldest_slot) return next_slot - oldest_slot;
      return slots - oldest_slot + next_slot;
   endfunction

   function int outstanding();
      return pending_results.size();
   endfunction

   function void log_request(brb_req_type req);
      brb_rsp_type r;
      int          cap;
      int          slots;
      int          fill;
      int          drop_n;
      int          to_end;
      cap   = usable();
      slots = cap + 1;
      fill  = bytes_held();
      r     = '0;
      case (req.opcode)
         OP_PUSH_OVR: begin
            if (fill >= cap) begin
               oldest_slot      = (oldest_slot + 1) % slots;
               r.dropped_oldest = 1'b1;
            end
            ring_bytes[next_slot] = req.data_byte;
            next_slot = (next_slot + 1) % slots;
            r.ok      = 1'b1;
         end
         OP_PUSH: begin
            if (fill < cap) begin
               ring_bytes[next_slot] = req.data_byte;
               next_slot = (next_slot + 1) % slots;
               r.ok      = 1'b1;
            end
         end
         OP_POP: begin
            if (fill > 0) begin
               r.data_out  = ring_bytes[oldest_slot];
               oldest_slot = (oldest_slot + 1) % slots;
               r.ok        = 1'b1;
            end
         end
         OP_PEEK: begin
            if (int'(req.count) < fill) begin
               r.data_out = ring_bytes[(oldest_slot + int'(req.count)) % slots];
               r.ok       = 1'b1;
            end
         end
         OP_DISCARD: begin
            drop_n      = (int'(req.count) < fill) ? int'(req.count) : fill;
            oldest_slot = (oldest_slot + drop_n) % slots;
            r.moved     = 10'(drop_n);
            r.ok        = 1'b1;
         end
         OP_CLEAR: begin
            oldest_slot = 0;
            next_slot   = 0;
            r.ok        = 1'b1;
         end
         default: begin
         end
      endcase
      fill              = bytes_held();
      to_end            = slots - oldest_slot;
      r.used_count      = 10'(fill);
      r.free_count      = 10'(cap - fill);
      r.contiguous_span = 10'((fill < to_end) ? fill : to_end);
      pending_results.push_back(r);
   endfunction

   function void compare_field(string name, int want, int got);
      if (want != got) begin
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
         errors++;
      end
   endfunction

   function void check_result(brb_rsp_type got);
      brb_rsp_type want;
      if (pending_results.size() == 0) begin
         $display("%0t: result with nothing expected, expected none, actual %h", $time, got);
         errors++;
         return;
      end
      want = pending_results.pop_front();
      compare_field("data_out", want.data_out, got.data_out);
      compare_field("ok", want.ok, got.ok);
      compare_field("dropped_oldest", want.dropped_oldest, got.dropped_oldest);
      compare_field("moved", want.moved, got.moved);
      compare_field("used_count", want.used_count, got.used_count);
      compare_field("free_count", want.free_count, got.free_count);
      compare_field("contiguous_span", want.contiguous_span, got.contiguous_span);
   endfunction
endclass

module byte_ring_buffer_fifo_test import brb_pkg::*; ();

   localparam logic [2:0] OP_SPARE_6   = 3'd6;
   localparam logic [2:0] OP_SPARE_7   = 3'd7;
   localparam int         STALL_LIMIT  = 3000;
   localparam int         HOLD_CYCLES  = 300;
   localparam int         SETTLE_CYCLES = 10;
   localparam int         NUM_PHASES   = 10;
   localparam int         PHASE_ITEMS  = 88;

   logic             clock;
   logic             reset;
   logic             req_valid;
   logic             req_ready;
   brb_req_type      req_data;
   logic             rsp_valid;
   logic             rsp_ready;
   brb_rsp_type      rsp_data;
   logic             csr_we;
   logic [CAP_W-1:0] csr_wdata;

   byte_ring_tracker tracker;
   int               tx_max_gap = 6;
   int               rx_max_gap = 6;
   bit               long_hold_req = 1'b0;
   int               stall_cycles = 0;

   // A negative entry asks for a random capacity.
   int phase_cap [NUM_PHASES] = '{1, 2, 3, 7, 1023, 40, -1, 0, 200, 1023};

   byte_ring_buffer_fifo dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata)
   );

   always begin
      clock = 1'b0;
      #1;
      clock = 1'b1;
      #1;
   end

   // Any transfer on either channel restarts the count.
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         stall_cycles <= 0;
      end else begin
         stall_cycles <= stall_cycles + 1;
         if (stall_cycles >= STALL_LIMIT) begin
            $display("TEST FAILED");
            $finish;
         end
      end
   end

   // Result side: waits a random number of cycles before each transfer, or a long
   // stretch when asked, so that the block backs up and stalls its input.
   initial begin
      int gap;
      rsp_ready <= 1'b0;
      wait (reset == 1'b0);
      @(posedge clock);
      forever begin
         gap = $urandom_range(0, rx_max_gap);
         if (long_hold_req) begin
            gap           = HOLD_CYCLES;
            long_hold_req = 1'b0;
         end
         if (gap > 0) begin
            rsp_ready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!rsp_valid);
         tracker.check_result(rsp_data);
      end
   end

   // Valid is only lowered when a gap follows, so it never sees two updates in one step.
   task automatic send_item(input brb_req_type item);
      int gap;
      gap = $urandom_range(0, tx_max_gap);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      do @(posedge clock); while (!req_ready);
      tracker.log_request(item);
   endtask

   task automatic send_op(input logic [2:0] op, input logic [7:0] value,
                          input logic [9:0] cnt);
      brb_req_type item;
      item.opcode    = op;
      item.data_byte = value;
      item.count     = cnt;
      send_item(item);
   endtask

   task automatic drain_results();
      req_valid <= 1'b0;
      while (tracker.outstanding() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_capacity(input logic [CAP_W-1:0] value);
      csr_we    <= 1'b1;
      csr_wdata <= value;
      @(posedge clock);
      csr_we    <= 1'b0;
      tracker.load_capacity(value);
      repeat (2) @(posedge clock);
   endtask

   // Random requests, weighted towards pushes and pops so that the ring fills,
   // empties and wraps; counts mostly fall between zero and one past the fill level.
   task automatic run_random(input int n);
      brb_req_type item;
      int          pick;
      int          fill;
      for (int i = 0; i < n; i++) begin
         pick = $urandom_range(0, 99);
         fill = tracker.bytes_held();
         if (pick < 27) item.opcode = OP_PUSH_OVR;
         else if (pick < 54) item.opcode = OP_PUSH;
         else if (pick < 72) item.opcode = OP_POP;
         else if (pick < 84) item.opcode = OP_PEEK;
         else if (pick < 92) item.opcode = OP_DISCARD;
         else if (pick < 96) item.opcode = OP_CLEAR;
         else if (pick < 98) item.opcode = OP_SPARE_6;
         else item.opcode = OP_SPARE_7;
         item.data_byte = 8'($urandom_range(0, 255));
         if ($urandom_range(0, 9) < 7) item.count = 10'($urandom_range(0, fill + 1));
         else item.count = 10'($urandom_range(0, 1023));
         send_item(item);
         if (i == n / 2) drain_results();
      end
   endtask

   initial begin
      logic [CAP_W-1:0] cap_value;
      tracker   = new();
      reset     <= 1'b1;
      req_valid <= 1'b0;
      req_data  <= '0;
      csr_we    <= 1'b0;
      csr_wdata <= '0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Reset capacity: empty-ring reads, clamped discard, offsets past the end.
      send_op(OP_POP, 8'h00, 10'd0);
      send_op(OP_PEEK, 8'h00, 10'd0);
      send_op(OP_DISCARD, 8'hFF, 10'd1023);
      send_op(OP_PUSH_OVR, 8'h00, 10'd0);
      send_op(OP_PUSH, 8'hFF, 10'd1023);
      send_op(OP_PEEK, 8'h55, 10'd1);
      send_op(OP_PEEK, 8'hAA, 10'd2);
      send_op(OP_PEEK, 8'h00, 10'd1023);
      send_op(OP_SPARE_6, 8'hFF, 10'd1023);
      send_op(OP_SPARE_7, 8'h00, 10'd0);
      send_op(OP_POP, 8'h00, 10'd0);
      send_op(OP_DISCARD, 8'h00, 10'd5);
      send_op(OP_CLEAR, 8'hFF, 10'd1023);
      send_op(OP_PUSH, 8'h81, 10'd0);
      send_op(OP_POP, 8'h00, 10'd0);
      drain_results();

      // A zero capacity behaves as one byte: refused push, then an overwrite.
      write_capacity(10'd0);
      send_op(OP_PUSH, 8'hA5, 10'd0);
      send_op(OP_PUSH, 8'h5A, 10'd0);
      send_op(OP_PUSH_OVR, 8'h3C, 10'd0);
      send_op(OP_PEEK, 8'h00, 10'd0);
      send_op(OP_POP, 8'h00, 10'd0);
      send_op(OP_POP, 8'h00, 10'd0);
      send_op(OP_DISCARD, 8'h00, 10'd0);
      drain_results();

      for (int p = 0; p < NUM_PHASES; p++) begin
         cap_value = (phase_cap[p] < 0) ? 10'($urandom_range(1, 1022)) : 10'(phase_cap[p]);
         write_capacity(cap_value);
         tx_max_gap = (p % 4 == 1 || p % 4 == 3) ? 0 : 6;
         rx_max_gap = (p % 4 >= 2) ? 0 : 6;
         run_random(PHASE_ITEMS);
         drain_results();
      end

      // Back-pressure: the result side holds off while requests keep coming.
      write_capacity(10'd8);
      tx_max_gap    = 0;
      rx_max_gap    = 6;
      long_hold_req = 1'b1;
      run_random(50);
      drain_results();

      if (tracker.errors == 0 && tracker.outstanding() == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule

### files.f
design/brb_pkg.sv
design/brb_ctrl.sv
design/brb_datapath.sv
design/byte_ring_buffer_fifo.sv
tb/byte_ring_buffer_fifo_test.sv
